// ===== src/equivalence_relation_checker_core_defines.svh =====
// assertion macros for the equivalence relation checker
`ifndef EQUIVALENCE_RELATION_CHECKER_CORE_DEFINES_SVH
`define EQUIVALENCE_RELATION_CHECKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ERC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ERC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ERC_ASSERT(label, clk, rst_n, prop, msg)
`define ERC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== src/erc_pkg.sv =====
// shared types and constants for the equivalence relation checker
package erc_pkg;

  localparam int unsigned NumSymbolsDef = 64;
  localparam int unsigned SymW          = 6;
  localparam int unsigned OpW           = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD_MEMBER = 2'd0,
    OP_ADD_PAIR   = 2'd1,
    OP_EVAL       = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ROW,
    ST_CAP_ROW,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic add_member;
    logic add_pair;
    logic clear;
    logic init_eval;
    logic rd_row;
    logic cap_row;
    logic scan;
    logic next_row;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
  } dp_status_t;

endpackage

// ===== src/erc_ctrl.sv =====
// controller state machine: decodes transactions and sequences the evaluation walk
module erc_ctrl import erc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   opcode_i,
  input  dp_status_t       status_i,
  output ctrl_cmd_t        cmd_o,
  output logic             busy_o
);

  state_e state_q, state_d;
  op_e    op;

  assign op     = op_e'(opcode_i);
  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && (op == OP_EVAL)) begin
          state_d = ST_RD_ROW;
        end
      end
      ST_RD_ROW:  state_d = ST_CAP_ROW;
      ST_CAP_ROW: state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.j_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = status_i.i_last ? ST_DONE : ST_RD_ROW;
      end
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (op)
            OP_ADD_MEMBER: cmd_o.add_member = 1'b1;
            OP_ADD_PAIR:   cmd_o.add_pair   = 1'b1;
            OP_EVAL:       cmd_o.init_eval  = 1'b1;
            OP_CLEAR:      cmd_o.clear      = 1'b1;
            default:       cmd_o            = '0;
          endcase
        end
      end
      ST_RD_ROW:  cmd_o.rd_row   = 1'b1;
      ST_CAP_ROW: cmd_o.cap_row  = 1'b1;
      ST_SCAN:    cmd_o.scan     = 1'b1;
      ST_DRAIN:   cmd_o.next_row = 1'b1;
      ST_DONE: begin
        cmd_o.emit  = 1'b1;
        cmd_o.clear = 1'b1;
      end
      default:    cmd_o = '0;
    endcase
  end

endmodule

// ===== src/erc_datapath.sv =====
// datapath: relation and transpose memories, member set, row walk and property flags
module erc_datapath import erc_pkg::*; #(
  parameter int unsigned NUM_SYMBOLS = NumSymbolsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       cmd_i,
  input  logic [SymW-1:0] sym_a_i,
  input  logic [SymW-1:0] sym_b_i,
  output dp_status_t      status_o,
  output logic            is_reflexive_o,
  output logic            is_symmetric_o,
  output logic            is_transitive_o
);

  localparam int unsigned AddrW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  logic [NUM_SYMBOLS-1:0] rows_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] cols_mem [NUM_SYMBOLS];

  logic [NUM_SYMBOLS-1:0] row_vld_q, col_vld_q, member_q;
  logic [NUM_SYMBOLS-1:0] row_rd_q, col_rd_q, rowi_q;
  logic                   row_rd_vld_q, col_rd_vld_q;
  logic [AddrW-1:0]       i_q, j_q, jd_q;
  logic                   chk_v_q;
  logic                   refl_q, sym_q, trans_q;

  logic [AddrW-1:0]       a_addr, b_addr, rd_addr;
  logic                   a_ok, b_ok, pair_we, rd_en;
  logic [NUM_SYMBOLS-1:0] one_a, one_b, row_mask, col_mask;
  logic [NUM_SYMBOLS-1:0] row_eff, col_eff;

  assign a_addr  = AddrW'(sym_a_i);
  assign b_addr  = AddrW'(sym_b_i);
  assign a_ok    = (32'(sym_a_i) < NUM_SYMBOLS);
  assign b_ok    = (32'(sym_b_i) < NUM_SYMBOLS);
  assign one_a   = NUM_SYMBOLS'(1) << a_addr;
  assign one_b   = NUM_SYMBOLS'(1) << b_addr;
  assign pair_we = cmd_i.add_pair && a_ok && b_ok;

  // a row never written since the last clear is taken whole
  assign row_mask = row_vld_q[a_addr] ? one_b : '1;
  assign col_mask = col_vld_q[b_addr] ? one_a : '1;

  assign rd_en   = cmd_i.rd_row || cmd_i.scan;
  assign rd_addr = cmd_i.rd_row ? i_q : j_q;

  assign row_eff = row_rd_vld_q ? row_rd_q : '0;
  assign col_eff = col_rd_vld_q ? col_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      for (int k = 0; k < NUM_SYMBOLS; k++) begin
        if (row_mask[k]) begin
          rows_mem[a_addr][k] <= one_b[k];
        end
        if (col_mask[k]) begin
          cols_mem[b_addr][k] <= one_a[k];
        end
      end
    end
    if (rd_en) begin
      row_rd_q <= rows_mem[rd_addr];
    end
    if (cmd_i.rd_row) begin
      col_rd_q <= cols_mem[i_q];
    end
    if (cmd_i.cap_row) begin
      rowi_q <= row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      col_vld_q    <= '0;
      member_q     <= '0;
      row_rd_vld_q <= 1'b0;
      col_rd_vld_q <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      jd_q         <= '0;
      chk_v_q      <= 1'b0;
      refl_q       <= 1'b1;
      sym_q        <= 1'b1;
      trans_q      <= 1'b1;
    end else begin
      if (cmd_i.clear) begin
        row_vld_q <= '0;
        col_vld_q <= '0;
        member_q  <= '0;
      end else begin
        if (pair_we) begin
          row_vld_q[a_addr] <= 1'b1;
          col_vld_q[b_addr] <= 1'b1;
        end
        if (cmd_i.add_member && a_ok) begin
          member_q[a_addr] <= 1'b1;
        end
      end

      if (rd_en) begin
        row_rd_vld_q <= row_vld_q[rd_addr];
      end
      if (cmd_i.rd_row) begin
        col_rd_vld_q <= col_vld_q[i_q];
      end

      chk_v_q <= cmd_i.scan;
      jd_q    <= j_q;

      if (cmd_i.init_eval) begin
        i_q     <= '0;
        refl_q  <= 1'b1;
        sym_q   <= 1'b1;
        trans_q <= 1'b1;
      end
      if (cmd_i.next_row) begin
        i_q <= i_q + AddrW'(1);
      end
      if (cmd_i.cap_row) begin
        j_q <= '0;
        if (row_eff != col_eff) begin
          sym_q <= 1'b0;
        end
        if (member_q[i_q] && !row_eff[i_q]) begin
          refl_q <= 1'b0;
        end
      end
      if (cmd_i.scan) begin
        j_q <= j_q + AddrW'(1);
      end
      // row j must lie within row i wherever bit (i,j) is set
      if (chk_v_q && rowi_q[jd_q] && (|(row_eff & ~rowi_q))) begin
        trans_q <= 1'b0;
      end
    end
  end

  assign status_o.i_last = (i_q == AddrW'(NUM_SYMBOLS - 1));
  assign status_o.j_last = (j_q == AddrW'(NUM_SYMBOLS - 1));

  assign is_reflexive_o  = refl_q;
  assign is_symmetric_o  = sym_q;
  assign is_transitive_o = trans_q;

endmodule

// ===== src/equivalence_relation_checker_core.sv =====
// equivalence relation checker top level
// member, pair and clear transactions give no result and leave the controller idle
// evaluate: busy from accept until the result strobe; the result comes from
// the row walk, which reads one row per cycle from the single-port relation memory
// the result is shown for one cycle and the receiver cannot stall
// reset empties all stores and returns the controller to idle
`include "equivalence_relation_checker_core_defines.svh"

module equivalence_relation_checker_core import erc_pkg::*; #(
  parameter int unsigned NUM_SYMBOLS = NumSymbolsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [OpW-1:0]  opcode_i,
  input  logic [SymW-1:0] sym_a_i,
  input  logic [SymW-1:0] sym_b_i,
  output logic            result_valid_o,
  output logic            is_reflexive_o,
  output logic            is_symmetric_o,
  output logic            is_transitive_o,
  output logic            is_equivalence_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  erc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  erc_datapath #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sym_a_i         (sym_a_i),
    .sym_b_i         (sym_b_i),
    .status_o        (status),
    .is_reflexive_o  (is_reflexive_o),
    .is_symmetric_o  (is_symmetric_o),
    .is_transitive_o (is_transitive_o)
  );

  assign result_valid_o   = cmd.emit;
  assign is_equivalence_o = is_reflexive_o && is_symmetric_o && is_transitive_o;

  `ERC_ASSERT(a_strobe_while_busy, clk_i, rst_ni, result_valid_o |-> busy, "result strobe outside an evaluate transaction")
  `ERC_ASSERT(a_idle_after_result, clk_i, rst_ni, result_valid_o |=> !busy, "checker still busy after result")
  `ERC_ASSERT(a_eval_sets_busy, clk_i, rst_ni, (start && !busy && (opcode_i == OP_EVAL)) |=> busy, "evaluate transaction did not start the walk")
  `ERC_ASSERT(a_busy_from_eval, clk_i, rst_ni, $rose(busy) |-> $past(start && (opcode_i == OP_EVAL)), "busy raised without an evaluate transaction")

endmodule
